// ===== rtl/pdcd_pkg.sv =====
`timescale 1ns / 1ps

package pdcd_pkg;

  // Fixed field widths of the block.
  localparam int FRAC_BITS  = 16;
  localparam int Q16_HALF   = 32768;
  localparam int BASE_W     = 33;
  localparam int SPP_W      = 32;
  localparam int GAIN_W     = 32;
  localparam int HEIGHT_W   = 10;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int COL_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BASE_W;

  // Signed Q28.16 sample positions (45 bits) and their rounded integer parts.
  localparam int PROD_XW = COL_W + SPP_W;
  localparam int POS_W   = PROD_XW + 3;
  localparam int RND_W   = POS_W - FRAC_BITS + 1;

  // Register reset values.
  localparam logic signed [BASE_W-1:0] RST_BASE   = '0;
  localparam logic [SPP_W-1:0]         RST_SPP    = SPP_W'(65536);
  localparam logic [GAIN_W-1:0]        RST_GAIN   = GAIN_W'(65536);
  localparam logic [HEIGHT_W-1:0]      RST_HEIGHT = HEIGHT_W'(217);

  localparam logic FUNC_STORE  = 1'b0;
  localparam logic FUNC_COLUMN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE,
    CFG_SPP,
    CFG_GAIN,
    CFG_HEIGHT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ROW_MEAN,
    ROW_TOP,
    ROW_BOTTOM
  } row_sel_t;

  // Tag that travels with a value through the row mapper.
  typedef struct packed {
    logic     vld;
    row_sel_t sel;
  } row_tag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_POS,
    ST_RND,
    ST_END,
    ST_LIM,
    ST_SCAN,
    ST_DIV,
    ST_ROW
  } state_t;

endpackage

// ===== rtl/pdcd_sample_mem.sv =====
`timescale 1ns / 1ps

module pdcd_sample_mem #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule

// ===== rtl/pdcd_divider.sv =====
`timescale 1ns / 1ps

module pdcd_divider #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int DC_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DC_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // Restoring division: one quotient bit per cycle, numerator bits shift
  // out of the top of quo_r while quotient bits shift in at the bottom.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DC_W'(NUM_W);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DC_W'(1);
      if (cnt_r == DC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== rtl/pdcd_row_map.sv =====
`timescale 1ns / 1ps

module pdcd_row_map
  import pdcd_pkg::*;
#(
  parameter int VAL_W = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  row_tag_t                in_tag,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [GAIN_W-1:0]       gain,
  input  logic [HEIGHT_W-1:0]     height,
  output row_tag_t                out_tag,
  output logic [ROW_W-1:0]        out_row
);

  localparam int PROD_W = VAL_W + GAIN_W + 1;
  localparam int Y_W    = PROD_W - FRAC_BITS;

  row_tag_t                  tag1_r, tag1_nxt;
  row_tag_t                  tag2_r, tag2_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [Y_W-1:0]     y;
  logic signed [Y_W-1:0]     h_s;
  logic signed [ROW_W:0]     y_cl;
  logic [ROW_W:0]            row_full;

  always_comb begin
    tag1_nxt = in_tag;
    tag2_nxt = tag1_r;
    prod_nxt = in_value * $signed({1'b0, gain});

    // An arithmetic shift is the floor of the Q16 product.
    prod_sh = prod_r >>> FRAC_BITS;
    y       = prod_sh[Y_W-1:0];
    h_s     = $signed({{(Y_W-HEIGHT_W){1'b0}}, height});
    if (y[Y_W-1]) begin
      y_cl = -(ROW_W+1)'(1);
    end else if (y > h_s) begin
      y_cl = $signed({2'b00, height}) + (ROW_W+1)'(1);
    end else begin
      y_cl = y[ROW_W:0];
    end
    // Rows count downward from the top of the plot.
    row_full = {2'b00, height} - (ROW_W+1)'(1) - y_cl;
    row_nxt  = row_full[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag1_nxt;
      tag2_r <= tag2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    row_r  <= row_nxt;
  end

  assign out_tag = tag2_r;
  assign out_row = row_r;

endmodule

// ===== rtl/peak_detect_column_decimator_top.sv =====
`timescale 1ns / 1ps

// Min/max/mean column decimator for a scope trace. A store request (in_func
// low) appends one sample to the sample memory in a single cycle and leaves
// busy low; once BUFFER_DEPTH samples are held further stores are dropped. A
// column request keeps busy high while the block works out the column's sample
// range, scans those samples, divides for the mean and maps the three rows:
// the single memory read port streams one sample per cycle, and the mean
// comes from a divider that produces one quotient bit per cycle.
// The result is shown for exactly one cycle with out_valid high, at the same
// edge busy falls, and must be taken then since there is no backpressure.
// The sample memory is not cleared at reset; only entries below the stored
// count are ever read.
module peak_detect_column_decimator_top
  import pdcd_pkg::*;
#(
  parameter int BUFFER_DEPTH = 65536,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_func,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_value,
  input  logic [COL_W-1:0]                       in_column_index,
  output logic                                   out_valid,
  output logic signed [ROW_W-1:0]                out_mean_row,
  output logic signed [ROW_W-1:0]                out_top_row,
  output logic signed [ROW_W-1:0]                out_bottom_row,
  output logic [$clog2(BUFFER_DEPTH+1)-1:0]      out_samples_used,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata
);

  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;

  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [POS_W-1:0] v);
    logic [POS_W-1:0] mag;
    logic [POS_W-1:0] r;
    mag = v[POS_W-1] ? $unsigned(-v) : $unsigned(v);
    r   = (mag + POS_W'(Q16_HALF)) >> FRAC_BITS;
    round_q16 = v[POS_W-1] ? -$signed(r[RND_W-1:0]) : $signed(r[RND_W-1:0]);
  endfunction

  state_t state_r, state_nxt;

  logic signed [BASE_W-1:0]      base_r, base_nxt;
  logic [SPP_W-1:0]              spp_r, spp_nxt;
  logic [GAIN_W-1:0]             gain_r, gain_nxt;
  logic [HEIGHT_W-1:0]           height_r, height_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;

  logic [COL_W-1:0]              col_r, col_nxt;
  logic [PROD_XW-1:0]            xprod_r, xprod_nxt;
  logic signed [POS_W-1:0]       pos0_r, pos0_nxt;
  logic signed [POS_W-1:0]       pos1_r, pos1_nxt;
  logic signed [RND_W-1:0]       start_r, start_nxt;
  logic signed [RND_W-1:0]       endr_r, endr_nxt;

  logic [CNT_W-1:0]              n_r, n_nxt;
  logic [ADDR_W-1:0]             addr_r, addr_nxt;
  logic [CNT_W-1:0]              remain_r, remain_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic                          first_r, first_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic signed [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic [1:0]                    row_cnt_r, row_cnt_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]              mean_row_r, mean_row_nxt;
  logic [ROW_W-1:0]              top_row_r, top_row_nxt;
  logic [ROW_W-1:0]              bottom_row_r, bottom_row_nxt;
  logic [CNT_W-1:0]              used_r, used_nxt;

  logic                          accept;
  logic                          mem_we;
  logic                          mem_re;
  logic [SAMPLE_BITS-1:0]        mem_rdata;
  logic signed [SAMPLE_BITS-1:0] sample;

  logic signed [RND_W-1:0]       start_p1;
  logic signed [RND_W-1:0]       end_lo;
  logic signed [RND_W-1:0]       end_lim;
  logic signed [RND_W-1:0]       cnt_s;
  logic signed [RND_W-1:0]       span;

  logic                          div_start;
  logic                          div_done;
  logic [SUM_W-1:0]              div_num;
  logic [SUM_W-1:0]              div_quot;
  logic [SAMPLE_BITS:0]          quot_s;

  row_tag_t                      rm_tag_in;
  row_tag_t                      rm_tag_out;
  logic signed [SAMPLE_BITS-1:0] rm_value;
  logic [ROW_W-1:0]              rm_row;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign sample = $signed(mem_rdata);

  // Magnitude of the sum goes to the unsigned divider; the sign is put back
  // afterwards so the mean truncates toward zero.
  assign div_num = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign quot_s  = div_quot[SAMPLE_BITS:0];

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    spp_nxt        = spp_r;
    gain_nxt       = gain_r;
    height_nxt     = height_r;
    count_nxt      = count_r;
    col_nxt        = col_r;
    n_nxt          = n_r;
    addr_nxt       = addr_r;
    remain_nxt     = remain_r;
    rd_vld_nxt     = 1'b0;
    first_nxt      = first_r;
    sum_nxt        = sum_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    mean_nxt       = mean_r;
    row_cnt_nxt    = row_cnt_r;
    out_valid_nxt  = 1'b0;
    mean_row_nxt   = mean_row_r;
    top_row_nxt    = top_row_r;
    bottom_row_nxt = bottom_row_r;
    used_nxt       = used_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    div_start      = 1'b0;
    rm_tag_in.vld  = 1'b0;
    rm_tag_in.sel  = row_sel_t'(row_cnt_r);

    // The position pipeline runs every cycle; each step has its own state so
    // that the register ahead of it has settled.
    xprod_nxt = col_r * spp_r;
    pos0_nxt  = POS_W'(base_r) + $signed({{(POS_W-PROD_XW){1'b0}}, xprod_r});
    pos1_nxt  = pos0_r + $signed({{(POS_W-SPP_W){1'b0}}, spp_r});
    start_nxt = round_q16(pos0_r);
    if (start_nxt[RND_W-1]) begin
      start_nxt = '0;
    end
    endr_nxt  = round_q16(pos1_r);

    start_p1 = start_r + RND_W'(1);
    end_lo   = (endr_r < start_p1) ? start_p1 : endr_r;
    cnt_s    = $signed({{(RND_W-CNT_W){1'b0}}, count_r});
    end_lim  = (end_lo > cnt_s) ? cnt_s : end_lo;
    span     = end_lim - start_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BASE:   base_nxt   = $signed(cfg_wdata[BASE_W-1:0]);
        CFG_SPP:    spp_nxt    = cfg_wdata[SPP_W-1:0];
        CFG_GAIN:   gain_nxt   = cfg_wdata[GAIN_W-1:0];
        CFG_HEIGHT: height_nxt = cfg_wdata[HEIGHT_W-1:0];
        default:    ;
      endcase
    end

    // Samples arrive in the cycle after their read.
    if (rd_vld_r) begin
      sum_nxt   = sum_r + SUM_W'(sample);
      first_nxt = 1'b0;
      if (first_r || (sample < min_r)) begin
        min_nxt = sample;
      end
      if (first_r || (sample > max_r)) begin
        max_nxt = sample;
      end
    end

    case (rm_tag_out.sel)
      ROW_MEAN:   mean_row_nxt   = rm_tag_out.vld ? rm_row : mean_row_r;
      ROW_TOP:    top_row_nxt    = rm_tag_out.vld ? rm_row : top_row_r;
      ROW_BOTTOM: bottom_row_nxt = rm_tag_out.vld ? rm_row : bottom_row_r;
      default:    ;
    endcase

    case (rm_tag_in.sel)
      ROW_MEAN:   rm_value = mean_r;
      ROW_TOP:    rm_value = max_r;
      ROW_BOTTOM: rm_value = min_r;
      default:    rm_value = min_r;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_COLUMN) begin
            col_nxt   = in_column_index;
            state_nxt = ST_MUL;
          end else if (count_r < CNT_W'(BUFFER_DEPTH)) begin
            mem_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ST_MUL: state_nxt = ST_POS;
      ST_POS: state_nxt = ST_RND;
      ST_RND: state_nxt = ST_END;
      ST_END: state_nxt = ST_LIM;
      ST_LIM: begin
        n_nxt      = (end_lim > start_r) ? span[CNT_W-1:0] : '0;
        remain_nxt = n_nxt;
        addr_nxt   = start_r[ADDR_W-1:0];
        sum_nxt    = '0;
        min_nxt    = '0;
        max_nxt    = '0;
        first_nxt  = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (remain_r != '0) begin
          mem_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          addr_nxt   = addr_r + ADDR_W'(1);
          remain_nxt = remain_r - CNT_W'(1);
        end else if (!rd_vld_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (n_r == '0) begin
            mean_nxt = '0;
          end else if (sum_r[SUM_W-1]) begin
            mean_nxt = $signed(SAMPLE_BITS'(-quot_s));
          end else begin
            mean_nxt = $signed(quot_s[SAMPLE_BITS-1:0]);
          end
          row_cnt_nxt = '0;
          state_nxt   = ST_ROW;
        end
      end
      ST_ROW: begin
        if (row_cnt_r != 2'd3) begin
          rm_tag_in.vld = 1'b1;
          row_cnt_nxt   = row_cnt_r + 2'd1;
        end
        if (rm_tag_out.vld && (rm_tag_out.sel == ROW_BOTTOM)) begin
          out_valid_nxt = 1'b1;
          used_nxt      = n_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= RST_BASE;
      spp_r       <= RST_SPP;
      gain_r      <= RST_GAIN;
      height_r    <= RST_HEIGHT;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      spp_r       <= spp_nxt;
      gain_r      <= gain_nxt;
      height_r    <= height_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r        <= col_nxt;
    xprod_r      <= xprod_nxt;
    pos0_r       <= pos0_nxt;
    pos1_r       <= pos1_nxt;
    start_r      <= start_nxt;
    endr_r       <= endr_nxt;
    n_r          <= n_nxt;
    addr_r       <= addr_nxt;
    remain_r     <= remain_nxt;
    first_r      <= first_nxt;
    mean_r       <= mean_nxt;
    row_cnt_r    <= row_cnt_nxt;
    mean_row_r   <= mean_row_nxt;
    top_row_r    <= top_row_nxt;
    bottom_row_r <= bottom_row_nxt;
    used_r       <= used_nxt;
  end

  pdcd_sample_mem #(
    .DEPTH  (BUFFER_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_sample_value),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  pdcd_divider #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (n_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  pdcd_row_map #(
    .VAL_W (SAMPLE_BITS)
  ) u_row_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (rm_tag_in),
    .in_value (rm_value),
    .gain     (gain_r),
    .height   (height_r),
    .out_tag  (rm_tag_out),
    .out_row  (rm_row)
  );

  assign out_valid        = out_valid_r;
  assign out_mean_row     = $signed(mean_row_r);
  assign out_top_row      = $signed(top_row_r);
  assign out_bottom_row   = $signed(bottom_row_r);
  assign out_samples_used = used_r;

endmodule

// ===== rtl/pdcd_checker.sv =====
`timescale 1ns / 1ps

module pdcd_checker
  import pdcd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_func,
  input logic out_valid
);

  // A column request always raises busy.
  a_column_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_COLUMN)) |=> busy)
    else $error("column request did not raise busy");

  // A store request completes in its own cycle.
  a_store_stays_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_STORE)) |=> !busy)
    else $error("store request raised busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Every column request ends with exactly its result, shown as busy drops.
  a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result shown outside the end of a column request");

endmodule

bind peak_detect_column_decimator_top pdcd_checker u_pdcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_func   (in_func),
  .out_valid (out_valid)
);

// ===== sim/peak_detect_column_decimator_top_test.sv =====
`timescale 1ns / 1ps

module peak_detect_column_decimator_top_test;
  import pdcd_pkg::*;

  localparam int TRACE_DEPTH    = 65536;
  localparam int SAMPLE_BITS    = 24;
  localparam int USED_W         = $clog2(TRACE_DEPTH + 1);
  // The longest column request walks the whole trace with nothing accepted.
  localparam int WATCHDOG_LIMIT = 300000;

  typedef struct packed {
    logic [ROW_W-1:0]  mean_row;
    logic [ROW_W-1:0]  top_row;
    logic [ROW_W-1:0]  bottom_row;
    logic [USED_W-1:0] used;
  } column_rows_t;

  class decimator_scoreboard;
    logic signed [SAMPLE_BITS-1:0] trace_mem [TRACE_DEPTH];
    int unsigned  trace_len;
    longint       base_q16;
    longint       step_q16;
    longint       gain_q16;
    longint       height;
    column_rows_t expected_columns[$];
    int           errors;

    function new();
      trace_len = 0;
      base_q16  = 0;
      step_q16  = 65536;
      gain_q16  = 65536;
      height    = 217;
      errors    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE:   base_q16 = longint'($signed(data));
        CFG_SPP:    step_q16 = longint'(data[SPP_W-1:0]);
        CFG_GAIN:   gain_q16 = longint'(data[GAIN_W-1:0]);
        CFG_HEIGHT: height   = longint'(data[HEIGHT_W-1:0]);
        default:    ;
      endcase
    endfunction

    // Halves round away from zero.
    function longint round_q16(longint v);
      if (v >= 0) return (v + 32768) >>> 16;
      return -((-v + 32768) >>> 16);
    endfunction

    function logic [ROW_W-1:0] to_row(int v);
      longint p;
      longint y;
      p = longint'(v) * gain_q16;
      if (p >= 0) y = p >>> 16;
      else y = -((-p + 65535) >>> 16);
      if (y < 0) y = -1;
      if (y > height) y = height + 1;
      return ROW_W'(height - 1 - y);
    endfunction

    function int pending();
      return expected_columns.size();
    endfunction

    function void note_request(logic func, logic signed [SAMPLE_BITS-1:0] value,
                               logic [COL_W-1:0] column);
      longint       x;
      longint       lo;
      longint       hi;
      longint       n;
      longint       total;
      int           s;
      int           lo_val;
      int           hi_val;
      int           avg;
      column_rows_t e;
      if (func == FUNC_STORE) begin
        if (trace_len < TRACE_DEPTH) begin
          trace_mem[trace_len] = value;
          trace_len++;
        end
        return;
      end
      x  = longint'(column);
      lo = round_q16(base_q16 + x * step_q16);
      hi = round_q16(base_q16 + (x + 1) * step_q16);
      if (lo < 0) lo = 0;
      if (hi < lo + 1) hi = lo + 1;
      if (hi > longint'(trace_len)) hi = longint'(trace_len);
      n = 0;
      total = 0;
      lo_val = 0;
      hi_val = 0;
      for (longint i = lo; i < hi; i++) begin
        s = trace_mem[i];
        if (n == 0) begin
          lo_val = s;
          hi_val = s;
        end else begin
          if (s < lo_val) lo_val = s;
          if (s > hi_val) hi_val = s;
        end
        total += s;
        n++;
      end
      avg = (n > 0) ? int'(total / n) : 0;
      e.mean_row   = to_row(avg);
      e.top_row    = to_row(hi_val);
      e.bottom_row = to_row(lo_val);
      e.used       = USED_W'(n);
      expected_columns.push_back(e);
    endfunction

    function void check_column(logic [ROW_W-1:0] mean_row, logic [ROW_W-1:0] top_row,
                               logic [ROW_W-1:0] bottom_row, logic [USED_W-1:0] used);
      column_rows_t e;
      if (expected_columns.size() == 0) begin
        $error("column result with no request outstanding");
        errors++;
        return;
      end
      e = expected_columns.pop_front();
      if (mean_row !== e.mean_row) begin
        $error("mean_row expected %0d actual %0d", $signed(e.mean_row), $signed(mean_row));
        errors++;
      end
      if (top_row !== e.top_row) begin
        $error("top_row expected %0d actual %0d", $signed(e.top_row), $signed(top_row));
        errors++;
      end
      if (bottom_row !== e.bottom_row) begin
        $error("bottom_row expected %0d actual %0d", $signed(e.bottom_row),
               $signed(bottom_row));
        errors++;
      end
      if (used !== e.used) begin
        $error("samples_used expected %0d actual %0d", e.used, used);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n           = 1'b0;
  logic                          start           = 1'b0;
  logic                          busy;
  logic                          in_func         = 1'b0;
  logic signed [SAMPLE_BITS-1:0] in_sample_value = '0;
  logic [COL_W-1:0]              in_column_index = '0;
  logic                          out_valid;
  logic signed [ROW_W-1:0]       out_mean_row;
  logic signed [ROW_W-1:0]       out_top_row;
  logic signed [ROW_W-1:0]       out_bottom_row;
  logic [USED_W-1:0]             out_samples_used;
  logic                          cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index       = '0;
  logic [CFG_DATA_W-1:0]         cfg_wdata       = '0;

  decimator_scoreboard sb;
  int                  idle_pct = 0;
  int                  quiet_cycles = 0;

  peak_detect_column_decimator_top #(
    .BUFFER_DEPTH(TRACE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_sample_value (in_sample_value),
    .in_column_index (in_column_index),
    .out_valid       (out_valid),
    .out_mean_row    (out_mean_row),
    .out_top_row     (out_top_row),
    .out_bottom_row  (out_bottom_row),
    .out_samples_used(out_samples_used),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_column(out_mean_row, out_top_row, out_bottom_row, out_samples_used);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Holds the request until it is taken; start stays high for the next one
  // unless the sender decides to idle.
  task automatic issue(input logic func, input logic signed [SAMPLE_BITS-1:0] value,
                       input logic [COL_W-1:0] column);
    start           <= 1'b1;
    in_func         <= func;
    in_sample_value <= value;
    in_column_index <= column;
    do @(posedge clk); while (busy);
    sb.note_request(func, value, column);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic store(input logic signed [SAMPLE_BITS-1:0] value);
    issue(FUNC_STORE, value, COL_W'($urandom));
  endtask

  task automatic query(input logic [COL_W-1:0] column);
    issue(FUNC_COLUMN, SAMPLE_BITS'($urandom), column);
  endtask

  // A store gives no result, so settling waits for every column result and for busy to fall.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] base, input logic [SPP_W-1:0] step,
                           input logic [GAIN_W-1:0] gain, input logic [HEIGHT_W-1:0] height);
    settle();
    write_reg(CFG_BASE, base);
    write_reg(CFG_SPP, CFG_DATA_W'(step));
    write_reg(CFG_GAIN, CFG_DATA_W'(gain));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(height));
    cfg_we <= 1'b0;
  endtask

  task automatic random_setup();
    logic [CFG_DATA_W-1:0] base;
    logic [SPP_W-1:0]      step;
    logic [GAIN_W-1:0]     gain;
    logic [HEIGHT_W-1:0]   height;
    case ($urandom_range(0, 9))
      0:       base = 33'h1_0000_0000;
      1:       base = 33'h0_FFFF_FFFF;
      default: base = CFG_DATA_W'(
                 longint'(int'($urandom_range(0, sb.trace_len + 64)) - 48) * 65536
                 + $urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 9))
      0:       step = '0;
      1:       step = 32'd1;
      2:       step = '1;
      3:       step = $urandom;
      default: step = $urandom_range(32'h1000, 32'h10_0000);
    endcase
    case ($urandom_range(0, 9))
      0:       gain = '0;
      1:       gain = '1;
      2:       gain = $urandom;
      3, 4:    gain = $urandom_range(0, 64);
      default: gain = $urandom_range(0, 32'h4_0000);
    endcase
    case ($urandom_range(0, 9))
      0:       height = '0;
      1:       height = 10'd1;
      2:       height = '1;
      default: height = HEIGHT_W'($urandom_range(1, 1023));
    endcase
    configure(base, step, gain, height);
  endtask

  task automatic random_phase(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) random_setup();
      if ($urandom_range(99) < 60) begin
        if ($urandom_range(1)) store(SAMPLE_BITS'($urandom));
        else store(SAMPLE_BITS'(int'($urandom_range(0, 600)) - 300));
      end else begin
        if ($urandom_range(1)) query(COL_W'($urandom));
        else query(COL_W'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one sample per column, unit gain.
    query(10'd0);
    store(24'sh7F_FFFF);
    store(24'sh80_0000);
    store(24'sh00_0000);
    store(24'shFF_FFFF);
    store(24'sh00_0001);
    store(24'sd100);
    store(-24'sd100);
    query(10'd0);
    query(10'd1);
    query(10'd6);
    query(10'd7);
    query(10'd1023);
    // Half-sample steps land on rounding halves; full gain saturates the rows.
    configure(33'h0_0000_0000, 32'h8000, '1, 10'd1023);
    query(10'd0);
    query(10'd1);
    // Negative base on a half, zero gain, zero height.
    configure(-33'sh1_8000, 32'h3_0000, '0, 10'd0);
    query(10'd0);
    query(10'd2);
    configure(33'h0_FFFF_FFFF, '1, 32'h1_0000, 10'd1);
    query(10'd0);
    configure(33'h1_0000_0000, 32'd1, 32'd1, 10'd1023);
    query(10'd1023);

    random_phase(480, 8);
    random_phase(480, 52);
    random_phase(480, 0);

    // Extreme samples at the end of the trace, then columns past its end and
    // one column that covers every stored sample.
    configure('0, 32'h1_0000, 32'h1_0000, 10'd217);
    idle_pct = 0;
    store(24'sh7F_FFFF);
    store(24'sh80_0000);
    store(24'sh12_3456);
    query(10'd1023);
    configure('0, 32'h40_0000, 32'h10, 10'd1023);
    query(10'd1023);
    configure('0, '1, 32'h3, 10'd512);
    query(10'd0);
    query(10'd1);

    settle();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
